FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, ignored while reset is high.
`define JABB_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("joint bound check failed");
// Next-cycle implication, ignored while reset is high.
`define JABB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("joint bound check failed");
// Next-cycle implication that also holds across reset.
`define JABB_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("joint bound check failed");
`endif

FILE: rtl/jabb_pkg.sv
// Shared types and constants of the joint step bound block.
package jabb_pkg;
  localparam int DT_W      = 24;
  localparam int SQ_STEPS  = 32;
  localparam int SQ_LANES  = 3;
  localparam logic [DT_W-1:0] DT_RESET = 24'd167772;
  localparam int LANE_HI   = 0;
  localparam int LANE_LO   = 1;
  localparam int LANE_TGT  = 2;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] pos_min;
    logic signed [31:0] pos_max;
    logic               min_limited;
    logic               max_limited;
    logic [30:0]        accel_limit;
    logic               accel_unlimited;
    logic signed [31:0] prev_velocity;
    logic signed [31:0] target_disp;
    logic               target_present;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic               unbounded;
  } out_item_t;

  // Control and box data that travel alongside the root lanes.
  typedef struct packed {
    logic signed [63:0] acc_lo;
    logic signed [63:0] acc_hi;
    logic               hi_lim;
    logic               lo_lim;
    logic               tgt_pos;
    logic               tgt_neg;
    logic               a_inf;
    logic               a_zero;
  } side_t;
endpackage

FILE: rtl/jabb_root_pipe.sv
// Pipelined square root, three lanes, one result bit per stage.
module jabb_root_pipe (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [jabb_pkg::SQ_LANES-1:0][63:0]   rad,
  input  jabb_pkg::side_t                       side_in,
  output logic                                  out_valid,
  output logic [jabb_pkg::SQ_LANES-1:0][31:0]   root,
  output logic [jabb_pkg::SQ_LANES-1:0][32:0]   rem,
  output jabb_pkg::side_t                       side_out
);
  import jabb_pkg::*;

  logic [SQ_STEPS:0]                       vld;
  logic [SQ_LANES-1:0][63:0]               xq   [0:SQ_STEPS];
  logic [SQ_LANES-1:0][31:0]               rq   [0:SQ_STEPS];
  logic [SQ_LANES-1:0][32:0]               mq   [0:SQ_STEPS];
  side_t                                   sq   [0:SQ_STEPS];

  // The stage zero view is the input itself.
  assign vld[0] = in_valid;
  assign xq[0]  = rad;
  assign rq[0]  = '0;
  assign mq[0]  = '0;
  assign sq[0]  = side_in;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [SQ_LANES-1:0][63:0] x_next;
    logic [SQ_LANES-1:0][31:0] r_next;
    logic [SQ_LANES-1:0][32:0] m_next;

    // Bring down two radicand bits and try the next root bit in each lane.
    always_comb begin
      logic [34:0] part;
      logic [34:0] trial;
      logic        ge;
      for (int l = 0; l < SQ_LANES; l++) begin
        part      = {mq[k][l], xq[k][l][63:62]};
        trial     = {1'b0, rq[k][l], 2'b01};
        ge        = (part >= trial);
        m_next[l] = ge ? 33'(part - trial) : part[32:0];
        r_next[l] = {rq[k][l][30:0], ge};
        x_next[l] = {xq[k][l][61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        xq[k+1] <= x_next;
        rq[k+1] <= r_next;
        mq[k+1] <= m_next;
        sq[k+1] <= sq[k];
      end
    end
  end

  assign out_valid = vld[SQ_STEPS];
  assign root      = rq[SQ_STEPS];
  assign rem       = mq[SQ_STEPS];
  assign side_out  = sq[SQ_STEPS];
endmodule

FILE: rtl/joint_accel_brake_bound_core.sv
// Top level of the joint step bound block: box, braking roots, clamping.
// Each item is one joint; a new item may enter in every clock cycle unless the
// pipeline holds. An item passes four front stages for the distances,
// radicands and acceleration box, 32 stages of the root pipeline that each
// settle one root bit, then rounding, the dt products, the target selection,
// the clamp and the output register. The throughput is one item per cycle
// while nothing holds. The pipeline holds when its last stage is full and the
// output register still waits to be taken. step_time may be written only while
// no item is in flight.
module joint_accel_brake_bound_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jabb_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jabb_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [23:0]          cfg_data
);
  import jabb_pkg::*;

  logic [DT_W-1:0] step_time;
  logic            en;
  logic            v1, v2, v3, v4, vr, vq1, vq2, vq3;

  // Stage registers.
  in_item_t                  s1;
  logic [31:0]               d_hi, d_lo, d_tg;
  logic signed [63:0]        prev2, prev3;
  logic [54:0]               ax;
  logic [30:0]               a2;
  side_t                     side2, side3, side4;
  logic [SQ_LANES-1:0][63:0] rad3, rad4;
  logic [54:0]               bh;
  logic [47:0]               bl;
  logic                      sq_valid;
  logic [SQ_LANES-1:0][31:0] sq_root;
  logic [SQ_LANES-1:0][32:0] sq_rem;
  side_t                     sq_side, side_r, side_q1, side_q2, side_q3;
  logic [SQ_LANES-1:0][32:0] sr;
  logic [SQ_LANES-1:0][56:0] bq;
  logic signed [63:0]        br_hi, br_lo;
  logic                      hi_ok, lo_ok;
  logic signed [63:0]        upper, lower;
  out_item_t                 res;

  // The whole pipeline moves unless a full last stage meets a held output.
  assign en       = !(out_valid && !out_ready && vq3);
  assign in_ready = en;

  // Control period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= DT_RESET;
    end else if (cfg_we) begin
      step_time <= cfg_data;
    end
  end

  // Valid bits of the stages outside the root pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      vr  <= 1'b0;
      vq1 <= 1'b0;
      vq2 <= 1'b0;
      vq3 <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      vr  <= sq_valid;
      vq1 <= vr;
      vq2 <= vq1;
      vq3 <= vq2;
    end
  end

  // Stage 1 holds the accepted item.
  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= in_item;
    end
  end

  // Stage 2: distances, previous step and the first box product.
  always_ff @(posedge clk) begin
    logic signed [32:0] dh, dl;
    dh = 33'(s1.pos_max) - 33'(s1.position);
    dl = 33'(s1.position) - 33'(s1.pos_min);
    if (en) begin
      d_hi  <= (dh > 0) ? dh[31:0] : '0;
      d_lo  <= (dl > 0) ? dl[31:0] : '0;
      d_tg  <= s1.target_disp[31] ? 32'(-33'(s1.target_disp)) : s1.target_disp;
      prev2 <= 64'(s1.prev_velocity * $signed({1'b0, step_time}));
      ax    <= s1.accel_limit * step_time;
      a2    <= s1.accel_limit;
      side2.acc_lo  <= '0;
      side2.acc_hi  <= '0;
      side2.hi_lim  <= s1.max_limited;
      side2.lo_lim  <= s1.min_limited;
      side2.tgt_pos <= s1.target_present && !s1.target_disp[31] && (s1.target_disp != 0);
      side2.tgt_neg <= s1.target_present && s1.target_disp[31];
      side2.a_inf   <= s1.accel_unlimited;
      side2.a_zero  <= (s1.accel_limit == '0);
    end
  end

  // Stage 3: radicands 2*a*d and the split dt products of the box.
  always_ff @(posedge clk) begin
    if (en) begin
      rad3[LANE_HI]  <= {63'(a2 * d_hi), 1'b0};
      rad3[LANE_LO]  <= {63'(a2 * d_lo), 1'b0};
      rad3[LANE_TGT] <= {63'(a2 * d_tg), 1'b0};
      bh             <= ax[54:24] * step_time;
      bl             <= ax[23:0] * step_time;
      prev3          <= prev2;
      side3          <= side2;
    end
  end

  // Stage 4: acceleration box around the previous step.
  always_ff @(posedge clk) begin
    logic [63:0] box;
    side_t       sd;
    box       = 64'(bh) + 64'((49'(bl) + 49'h80_0000) >> DT_W);
    sd        = side3;
    sd.acc_lo = prev3 - $signed(box);
    sd.acc_hi = prev3 + $signed(box);
    if (en) begin
      rad4  <= rad3;
      side4 <= sd;
    end
  end

  jabb_root_pipe u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .rad       (rad4),
    .side_in   (side4),
    .out_valid (sq_valid),
    .root      (sq_root),
    .rem       (sq_rem),
    .side_out  (sq_side)
  );

  // Round each root to nearest.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < SQ_LANES; l++) begin
        sr[l] <= 33'(sq_root[l]) + 33'(sq_rem[l] > 33'(sq_root[l]));
      end
      side_r <= sq_side;
    end
  end

  // Braking distances scaled by dt.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < SQ_LANES; l++) begin
        bq[l] <= sr[l] * step_time;
      end
      side_q1 <= side_r;
    end
  end

  // Pick the tighter of limit and target on each side.
  always_ff @(posedge clk) begin
    logic signed [63:0] h, lw, t;
    logic               hk, lk;
    h  = 64'(bq[LANE_HI]);
    lw = -64'(bq[LANE_LO]);
    hk = side_q1.hi_lim;
    lk = side_q1.lo_lim;
    if (side_q1.tgt_pos) begin
      t = 64'(bq[LANE_TGT]);
      if (!hk || t < h) begin
        h = t;
      end
      hk = 1'b1;
    end else if (side_q1.tgt_neg) begin
      t = -64'(bq[LANE_TGT]);
      if (!lk || t > lw) begin
        lw = t;
      end
      lk = 1'b1;
    end
    if (en) begin
      br_hi   <= h;
      br_lo   <= lw;
      hi_ok   <= hk;
      lo_ok   <= lk;
      side_q2 <= side_q1;
    end
  end

  // Clamp the braking bounds into the box and intersect.
  always_ff @(posedge clk) begin
    logic signed [63:0] ch, cl, u, lw;
    u  = side_q2.acc_hi;
    lw = side_q2.acc_lo;
    ch = (br_hi < side_q2.acc_lo) ? side_q2.acc_lo : br_hi;
    cl = (br_lo > side_q2.acc_hi) ? side_q2.acc_hi : br_lo;
    if (hi_ok && ch < u) begin
      u = ch;
    end
    if (lo_ok && cl > lw) begin
      lw = cl;
    end
    if (en) begin
      upper   <= u;
      lower   <= lw;
      side_q3 <= side_q2;
    end
  end

  // Round half up to the output format, saturate, apply special cases.
  function automatic logic signed [31:0] to_out(input logic signed [63:0] v);
    logic signed [63:0] q;
    logic signed [39:0] r;
    q = v + 64'sh80_0000;
    r = 40'(q >>> DT_W);
    if (r > 40'sh00_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (r < -40'sh00_8000_0000) begin
      return 32'sh8000_0000;
    end
    return r[31:0];
  endfunction

  always_comb begin
    if (side_q3.a_inf) begin
      res.lower_bound = 32'sh8000_0000;
      res.upper_bound = 32'sh7FFF_FFFF;
      res.unbounded   = 1'b1;
    end else if (side_q3.a_zero) begin
      res = '0;
    end else begin
      res.lower_bound = to_out(lower);
      res.upper_bound = to_out(upper);
      res.unbounded   = 1'b0;
    end
  end

  // Output register; it loads whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= vq3;
    end
    if (!out_valid || out_ready) begin
      out_item <= res;
    end
  end
endmodule

FILE: rtl/jabb_checker.sv
// Port-level checker for the joint step bound block, with its bind.
`include "assert_macros.svh"
module jabb_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input jabb_pkg::out_item_t  out_item
);
  import jabb_pkg::*;

  // An unbounded item always carries the full range.
  `JABB_ASSERT(a_unb_range, out_valid && out_item.unbounded, out_item.lower_bound == 32'sh8000_0000 && out_item.upper_bound == 32'sh7FFF_FFFF)
  // An empty output register never blocks the input.
  `JABB_ASSERT(a_ready_empty, !out_valid, in_ready)
  // A waiting item stays put.
  `JABB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_item))
  // Reset empties the output.
  `JABB_ASSERT_ALWAYS(a_reset, rst, !out_valid)
endmodule

bind joint_accel_brake_bound_core jabb_checker u_jabb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

FILE: sim/bound_checker.sv
// Checker for the joint step bound block: predicts each result and compares it.
`timescale 1ns / 100ps
module bound_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  jabb_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  jabb_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  joints_checked
);
  import jabb_pkg::*;

  localparam logic [63:0] HALF_ULP = 64'h80_0000;
  localparam logic [63:0] ULP_MASK = 64'hFF_FFFF;

  logic [23:0] step_time;
  out_item_t   bound_queue[$];

  // Integer square root rounded to nearest.
  function automatic logic [63:0] round_root(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r + ((x > r) ? 64'd1 : 64'd0);
  endfunction

  // Braking step dt*sqrt(2*a*d) with 40 fraction bits.
  function automatic longint brake_step(logic [63:0] dt, logic [63:0] a, logic [63:0] d);
    return longint'(round_root(2 * a * d) * dt);
  endfunction

  // Round half up to the output grid and saturate to 32 bits.
  function automatic logic [31:0] to_q16(longint v);
    longint q, r;
    q = v + longint'(HALF_ULP);
    if (q >= 0) r = longint'(64'(q) >> 24);
    else r = -longint'((64'(-q) + ULP_MASK) >> 24);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Step bounds for one joint item.
  function automatic out_item_t joint_bounds(in_item_t it, logic [23:0] dt_reg);
    out_item_t o;
    logic [63:0] dt, a, x, ab;
    longint pos, pmin, pmax, vel, tgt, prev_term, box, lo_box, hi_box, d, t;
    longint stop_hi, stop_lo, upper, lower;
    bit has_hi, has_lo;
    dt = 64'(dt_reg);
    a = 64'(it.accel_limit);
    pos = longint'(it.position);
    pmin = longint'(it.pos_min);
    pmax = longint'(it.pos_max);
    vel = longint'(it.prev_velocity);
    tgt = longint'(it.target_disp);
    o = '0;
    if (it.accel_unlimited) begin
      o.lower_bound = 32'h8000_0000;
      o.upper_bound = 32'h7FFF_FFFF;
      o.unbounded = 1'b1;
      return o;
    end
    if (a == 0) return o;
    prev_term = vel * longint'(dt);
    x = a * dt;
    ab = (x >> 24) * dt + (((x & ULP_MASK) * dt + HALF_ULP) >> 24);
    box = longint'(ab);
    lo_box = prev_term - box;
    hi_box = prev_term + box;
    has_hi = 0;
    has_lo = 0;
    stop_hi = 0;
    stop_lo = 0;
    if (it.max_limited) begin
      d = pmax - pos;
      stop_hi = brake_step(dt, a, 64'((d > 0) ? d : 0));
      has_hi = 1;
    end
    if (it.min_limited) begin
      d = pos - pmin;
      stop_lo = -brake_step(dt, a, 64'((d > 0) ? d : 0));
      has_lo = 1;
    end
    if (it.target_present) begin
      if (tgt > 0) begin
        t = brake_step(dt, a, 64'(tgt));
        if (!has_hi || t < stop_hi) stop_hi = t;
        has_hi = 1;
      end else if (tgt < 0) begin
        t = -brake_step(dt, a, 64'(-tgt));
        if (!has_lo || t > stop_lo) stop_lo = t;
        has_lo = 1;
      end
    end
    upper = hi_box;
    lower = lo_box;
    if (has_hi) begin
      if (stop_hi < lo_box) stop_hi = lo_box;
      if (stop_hi < upper) upper = stop_hi;
    end
    if (has_lo) begin
      if (stop_lo > hi_box) stop_lo = hi_box;
      if (stop_lo > lower) lower = stop_lo;
    end
    o.lower_bound = to_q16(lower);
    o.upper_bound = to_q16(upper);
    return o;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = bound_queue.size();

  // Track the register, predict on input acceptance, compare on output acceptance.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      step_time <= DT_RESET;
      bound_queue.delete();
      fail_count <= 0;
      joints_checked <= 0;
    end else begin
      if (cfg_we) step_time <= cfg_data;
      if (in_valid && in_ready) bound_queue.push_back(joint_bounds(in_item, step_time));
      if (out_valid && out_ready) begin
        joints_checked <= joints_checked + 1;
        if (bound_queue.size() == 0) begin
          report_mismatch("unexpected item", 32'(out_item.unbounded), 0);
        end else begin
          want = bound_queue.pop_front();
          if (out_item.lower_bound !== want.lower_bound)
            report_mismatch("lower_bound", out_item.lower_bound, want.lower_bound);
          if (out_item.upper_bound !== want.upper_bound)
            report_mismatch("upper_bound", out_item.upper_bound, want.upper_bound);
          if (out_item.unbounded !== want.unbounded)
            report_mismatch("unbounded", 32'(out_item.unbounded), 32'(want.unbounded));
        end
      end
    end
  end
endmodule

FILE: sim/testbench.sv
// Testbench top: stimulus, receiver stalls and verdict for the joint step bound block.
`timescale 1ns / 100ps
module testbench;
  import jabb_pkg::*;

  localparam int LATENCY = 42;
  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready, cfg_we;
  in_item_t    in_item;
  out_item_t   out_item;
  logic [23:0] cfg_data;
  int          fail_count, pending, joints_checked, idle_cycles;
  bit          hold_receiver;

  joint_accel_brake_bound_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  bound_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending(pending), .joints_checked(joints_checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // A wide random value that favors extremes and small magnitudes.
  function automatic logic [31:0] pick32();
    unique case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // A joint item with mostly plausible geometry and random flags.
  function automatic in_item_t random_joint();
    in_item_t it;
    int p;
    it = '0;
    if ($urandom_range(0, 3) == 0) begin
      it.position = pick32();
      it.pos_min = pick32();
      it.pos_max = pick32();
      it.prev_velocity = pick32();
      it.target_disp = pick32();
      it.accel_limit = 31'(pick32());
    end else begin
      p = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      it.position = p;
      it.pos_min = p - int'($urandom_range(0, 1 << 22)) + 100;
      it.pos_max = p + int'($urandom_range(0, 1 << 22)) - 100;
      it.prev_velocity = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      it.target_disp = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      it.accel_limit = 31'($urandom_range(1, 1 << 24));
    end
    it.min_limited = $urandom_range(0, 3) != 0;
    it.max_limited = $urandom_range(0, 3) != 0;
    it.target_present = 1'($urandom_range(0, 1));
    it.accel_unlimited = $urandom_range(0, 15) == 0;
    if ($urandom_range(0, 19) == 0) it.accel_limit = 0;
    return it;
  endfunction

  // Offers one item and waits for the edge that takes it.
  task automatic send_joint(in_item_t it);
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk iff in_ready);
    @(negedge clk);
  endtask

  // Sends items in bursts with random gaps.
  task automatic send_burst_run(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        send_joint(random_joint());
        burst--;
        count--;
      end
      in_valid <= 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Waits for the pipeline to drain, then writes the step time.
  task automatic write_step_time(logic [23:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    @(negedge clk);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_receiver = 0;
      end else if (phase < 200) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        @(negedge clk);
      end
      phase = (phase + 1) % 600;
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d items outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    logic [23:0] step_times[4];
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_receiver = 0;
    idle_cycles = 0;
    step_times = '{24'd1, 24'hFF_FFFF, 24'd167772, 24'd0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: special cases and field extremes at the reset step time.
    it = '0;
    it.accel_unlimited = 1;
    it.accel_limit = 0;
    send_joint(it);
    it = '0;
    send_joint(it);
    it = '0;
    it.accel_limit = 31'h7FFF_FFFF;
    it.prev_velocity = 32'h7FFF_FFFF;
    send_joint(it);
    it.prev_velocity = 32'h8000_0000;
    send_joint(it);
    it = '0;
    it.accel_limit = 31'h1_0000;
    it.position = 32'h0010_0000;
    it.pos_min = 32'h0020_0000;
    it.pos_max = 32'h0000_0000;
    it.min_limited = 1;
    it.max_limited = 1;
    send_joint(it);
    it.position = 32'h8000_0000;
    it.pos_min = 32'h8000_0000;
    it.pos_max = 32'h7FFF_FFFF;
    send_joint(it);
    it.position = 32'h7FFF_FFFF;
    it.pos_min = 32'h8000_0000;
    it.accel_limit = 31'h7FFF_FFFF;
    send_joint(it);
    it = '0;
    it.accel_limit = 31'h2_0000;
    it.target_present = 1;
    it.target_disp = 32'h0001_0000;
    send_joint(it);
    it.target_disp = 32'hFFFF_0000;
    send_joint(it);
    it.target_disp = 0;
    send_joint(it);
    it.target_disp = 32'h8000_0000;
    send_joint(it);
    it.target_disp = 32'h7FFF_FFFF;
    it.max_limited = 1;
    it.pos_max = 32'h0000_0100;
    send_joint(it);
    it.min_limited = 1;
    it.pos_min = 32'hFFFF_FF00;
    it.target_disp = 32'hFFFF_FFFF;
    send_joint(it);
    it = '1;
    send_joint(it);
    it = '1;
    it.accel_unlimited = 0;
    send_joint(it);
    in_valid <= 1'b0;

    // Receiver holds off while the sender keeps offering items.
    hold_receiver = 1;
    send_burst_run(150);

    // The sender pauses until everything has drained.
    while (pending != 0) @(negedge clk);

    // Random phases over several step times, extremes included.
    foreach (step_times[i]) begin
      write_step_time(step_times[i]);
      send_burst_run(220);
    end
    write_step_time(24'($urandom_range(1, 24'hFF_FFFF)));
    send_burst_run(110);

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("Checked %0d joint results over directed corners and random phases", joints_checked);
    $display("at five step times including the smallest, largest and zero.");
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
